// File: hw/rtl/assert_macros.svh
// Assertion macros for the text console cursor control block.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TCC_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tcc: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define TCC_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tcc: next-cycle check failed");

`endif

// File: hw/rtl/tcc_pkg.sv
// Package for the text console cursor control block: widths, geometry,
// character codes, item classes and result actions. No dependencies.
`default_nettype none

package tcc_pkg;

	localparam int X_W    = 14;
	localparam int Y_W    = 16;
	localparam int DIM_W  = 14;
	localparam int CODE_W = 8;
	localparam int ACT_W  = 2;
	localparam int CFG_INDEX_W = 2;

	localparam int CELL_WIDTH  = 8;
	localparam int CELL_HEIGHT = 16;
	localparam int TAB_CELLS   = 8;
	localparam int LINE_GAP    = 2;
	localparam int BORDER      = 1;
	localparam int LINE_PITCH  = CELL_HEIGHT + LINE_GAP;
	localparam int TAB_STRIDE  = TAB_CELLS * CELL_WIDTH;
	localparam int TAB_SHIFT   = $clog2(TAB_STRIDE);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	localparam int TCC_QUEUE_DEPTH = 2;

	localparam logic [CODE_W-1:0] CHAR_BS = CODE_W'(8);
	localparam logic [CODE_W-1:0] CHAR_HT = CODE_W'(9);
	localparam logic [CODE_W-1:0] CHAR_LF = CODE_W'(10);
	localparam logic [CODE_W-1:0] CHAR_CR = CODE_W'(13);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CLS_NEWLINE,
		CLS_RETURN,
		CLS_BACKSPACE,
		CLS_TAB,
		CLS_PRINT
	} char_class_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_MOVE  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_ERASE = 2'd2,
		ACT_GLYPH = 2'd3
	} action_t;

	typedef struct packed {
		char_class_t         cls;
		logic [CODE_W-1:0]   code;
	} q_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_regs_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcc_front.sv
// Front end: accepts character items and classifies them for the queue.
// Depends on tcc_pkg.
`default_nettype none

module tcc_front (
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [tcc_pkg::CODE_W-1:0] char_code,
	input  wire tcc_pkg::q_status_t         q_status,
	output logic                            push,
	output tcc_pkg::q_item_t                item
);
	import tcc_pkg::*;

	char_class_t cls;

	always_comb begin
		case (char_code)
			CHAR_LF: cls = CLS_NEWLINE;
			CHAR_CR: cls = CLS_RETURN;
			CHAR_BS: cls = CLS_BACKSPACE;
			CHAR_HT: cls = CLS_TAB;
			default: cls = CLS_PRINT;
		endcase
	end

	assign in_ready  = !q_status.full;
	assign push      = in_valid && !q_status.full;
	assign item.cls  = cls;
	assign item.code = char_code;

endmodule

`default_nettype wire

// File: hw/rtl/tcc_queue.sv
// Short item queue between front and back end.
// Depends on tcc_pkg.
`default_nettype none

module tcc_queue #(
	parameter int DEPTH = tcc_pkg::TCC_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tcc_pkg::q_item_t  push_item,
	input  wire logic              pop,
	output tcc_pkg::q_status_t     status,
	output tcc_pkg::q_item_t       head
);
	import tcc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tcc_back.sv
// Back end: holds the cursor, carries out queued items and drives the
// result register. Depends on tcc_pkg.
`default_nettype none

module tcc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tcc_pkg::cfg_regs_t        cfg,
	input  wire tcc_pkg::q_status_t        q_status,
	input  wire tcc_pkg::q_item_t          head,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [tcc_pkg::ACT_W-1:0]      action,
	output logic [tcc_pkg::X_W-1:0]        pos_x,
	output logic [tcc_pkg::Y_W-1:0]        pos_y,
	output logic [tcc_pkg::CODE_W-1:0]     glyph_code,
	output logic                           last
);
	import tcc_pkg::*;

	logic [X_W-1:0]    cur_x_q;
	logic [Y_W-1:0]    cur_y_q;
	logic              second_q;
	logic              out_valid_q;
	action_t           act_q;
	logic [X_W-1:0]    pos_x_q;
	logic [Y_W-1:0]    pos_y_q;
	logic [CODE_W-1:0] glyph_q;
	logic              last_q;

	logic              fire;
	logic [Y_W:0]      lf_sum;
	logic [Y_W-1:0]    lf_y;
	logic              tab_wrap;
	logic [X_W-1:0]    tab_idx;
	logic [X_W-1:0]    tab_x;
	logic              glyph_wrap;
	logic [X_W-1:0]    gx;
	logic [Y_W-1:0]    gy;
	logic              need_clear;
	logic [X_W-1:0]    bs_x;

	action_t           n_act;
	logic [X_W-1:0]    n_px;
	logic [Y_W-1:0]    n_py;
	logic [CODE_W-1:0] n_glyph;
	logic              n_last;
	logic [X_W-1:0]    n_cx;
	logic [Y_W-1:0]    n_cy;
	logic              n_second;

	assign fire = q_status.valid && (!out_valid_q || out_ready);

	assign lf_sum = {1'b0, cur_y_q} + (Y_W + 1)'(LINE_PITCH);
	assign lf_y   = lf_sum[Y_W] ? '1 : lf_sum[Y_W-1:0];

	assign tab_wrap = ({1'b0, cur_x_q} + (X_W + 1)'(TAB_STRIDE)) >= {1'b0, cfg.width};
	assign tab_idx  = (cur_x_q - X_W'(BORDER)) >> TAB_SHIFT;
	assign tab_x    = (cur_x_q == '0) ? X_W'(BORDER) :
		X_W'(BORDER) + ((tab_idx + X_W'(1)) << TAB_SHIFT);

	assign bs_x = (cur_x_q < X_W'(CELL_WIDTH + BORDER)) ? X_W'(BORDER) :
		cur_x_q - X_W'(CELL_WIDTH);

	assign glyph_wrap = ({1'b0, cur_x_q} + (X_W + 1)'(CELL_WIDTH)) >= {1'b0, cfg.width};
	assign gx         = glyph_wrap ? X_W'(BORDER) : cur_x_q;
	assign gy         = glyph_wrap ? lf_y : cur_y_q;
	assign need_clear = ({1'b0, gy} + (Y_W + 1)'(CELL_HEIGHT + BORDER)) >=
		(Y_W + 1)'(cfg.height);

	always_comb begin
		n_act    = ACT_MOVE;
		n_px     = cur_x_q;
		n_py     = cur_y_q;
		n_glyph  = '0;
		n_last   = 1'b1;
		n_cx     = cur_x_q;
		n_cy     = cur_y_q;
		n_second = 1'b0;
		case (head.cls)
			CLS_NEWLINE: begin
				n_cx = X_W'(BORDER);
				n_cy = lf_y;
			end
			CLS_RETURN: begin
				n_cx = X_W'(BORDER);
			end
			CLS_BACKSPACE: begin
				n_act = ACT_ERASE;
				n_cx  = bs_x;
			end
			CLS_TAB: begin
				if (tab_wrap) begin
					n_cx = X_W'(BORDER);
					n_cy = lf_y;
				end else begin
					n_cx = tab_x;
				end
			end
			default: begin
				if (second_q) begin
					n_act   = ACT_GLYPH;
					n_glyph = head.code;
					n_cx    = cur_x_q + X_W'(CELL_WIDTH);
				end else if (need_clear) begin
					n_act    = ACT_CLEAR;
					n_last   = 1'b0;
					n_cx     = X_W'(BORDER);
					n_cy     = Y_W'(BORDER);
					n_second = 1'b1;
				end else begin
					n_act   = ACT_GLYPH;
					n_glyph = head.code;
					n_cx    = gx + X_W'(CELL_WIDTH);
					n_cy    = gy;
				end
			end
		endcase
		// moves report the new cursor; erase, clear and glyph report the cell
		case (n_act)
			ACT_GLYPH: begin
				n_px = second_q ? cur_x_q : gx;
				n_py = second_q ? cur_y_q : gy;
			end
			default: begin
				n_px = n_cx;
				n_py = n_cy;
			end
		endcase
	end

	assign pop = fire && !n_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= X_W'(BORDER);
			cur_y_q     <= Y_W'(BORDER);
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cur_x_q  <= n_cx;
				cur_y_q  <= n_cy;
				second_q <= n_second;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_q   <= n_act;
			pos_x_q <= n_px;
			pos_y_q <= n_py;
			glyph_q <= n_glyph;
			last_q  <= n_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = act_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign glyph_code = glyph_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_control.sv
// Top level of the text console cursor control block: config registers,
// front end, item queue and back end. Depends on tcc_pkg, tcc_front,
// tcc_queue, tcc_back and assert_macros.svh.
//
// channel  direction  handshake               payload
// in       sink       in_valid / in_ready     char_code
// out      source     out_valid / out_ready   action, pos_x, pos_y, glyph_code, last
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One character per cycle while the output is not stalled; a glyph that clears the
// screen gives two result items from the back end, a clear and then the glyph.
// A result item is registered in the back end; its character passes the item queue first.
// Reset gives 640 x 480 and cursor (1,1); no clearing pass.
// An output stall holds the back end; the queue keeps in_ready high until it fills.
`default_nettype none

`include "assert_macros.svh"

module text_console_cursor_control #(
	parameter int QUEUE_DEPTH = tcc_pkg::TCC_QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [tcc_pkg::CODE_W-1:0]      char_code,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [tcc_pkg::ACT_W-1:0]            action,
	output logic [tcc_pkg::X_W-1:0]              pos_x,
	output logic [tcc_pkg::Y_W-1:0]              pos_y,
	output logic [tcc_pkg::CODE_W-1:0]           glyph_code,
	output logic                                 last,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcc_pkg::DIM_W-1:0]       cfg_data
);
	import tcc_pkg::*;

	cfg_regs_t cfg_q;
	q_status_t q_status;
	q_item_t   push_item;
	q_item_t   head;
	logic      push;
	logic      pop;
	logic      at_home;
	logic      out_fire;
	logic      glyph_home;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	tcc_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_code(char_code),
		.q_status (q_status),
		.push     (push),
		.item     (push_item)
	);

	tcc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	tcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.glyph_code(glyph_code),
		.last      (last)
	);

	assign at_home    = (pos_x == X_W'(BORDER)) && (pos_y == Y_W'(BORDER));
	assign out_fire   = out_valid && out_ready;
	assign glyph_home = out_valid && last && (action == ACT_GLYPH) && at_home;

	`TCC_ASSERT_IMP(a_first_is_clear, clk, arst_n, out_valid && !last, action == ACT_CLEAR && at_home)
	`TCC_ASSERT_NXT(a_glyph_after_clear, clk, arst_n, out_fire && !last, glyph_home)
	`TCC_ASSERT_IMP(a_glyph_zero, clk, arst_n, out_valid && action != ACT_GLYPH, glyph_code == '0)

endmodule

`default_nettype wire

// File: bench/text_console_cursor_control_test.sv
// Self-checking bench for text_console_cursor_control: random and directed characters,
// cursor prediction in the bench, per-field compare of every result item.
// Depends on tcc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module text_console_cursor_control_test;
	import tcc_pkg::*;

	localparam int LIMIT_CYCLES   = 500000;
	localparam int RX_HOLD_CYCLES = 200;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		action_t           act;
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		logic [CODE_W-1:0] glyph;
		logic              fin;
	} cursor_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CODE_W-1:0] char_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ACT_W-1:0] action;
	logic [X_W-1:0] pos_x;
	logic [Y_W-1:0] pos_y;
	logic [CODE_W-1:0] glyph_code;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	logic [CODE_W-1:0] char_backlog[$];
	cursor_result_t due_results[$];
	int unsigned cur_x = BORDER;
	int unsigned cur_y = BORDER;
	int unsigned scr_w = WIDTH_RESET;
	int unsigned scr_h = HEIGHT_RESET;
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 27;
	int recv_idle_pct = 49;
	logic send_hold = 1'b0;
	logic rx_stall_go = 1'b0;
	int rx_stall_left = 0;

	text_console_cursor_control i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.glyph_code(glyph_code),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void post_result(input action_t act, input int unsigned x,
			input int unsigned y, input logic [CODE_W-1:0] glyph, input logic fin);
		cursor_result_t r;
		r.act = act;
		r.x = x[X_W-1:0];
		r.y = y[Y_W-1:0];
		r.glyph = glyph;
		r.fin = fin;
		due_results.push_back(r);
	endfunction

	function automatic void line_feed();
		int unsigned y;
		y = cur_y + LINE_PITCH;
		cur_y = (y > 65535) ? 65535 : y;
		cur_x = BORDER;
	endfunction

	function automatic void advance_cursor(input logic [CODE_W-1:0] code);
		case (code)
			CHAR_LF: begin
				line_feed();
				post_result(ACT_MOVE, cur_x, cur_y, '0, 1'b1);
			end
			CHAR_CR: begin
				cur_x = BORDER;
				post_result(ACT_MOVE, cur_x, cur_y, '0, 1'b1);
			end
			CHAR_BS: begin
				if (cur_x < CELL_WIDTH + BORDER)
					cur_x = BORDER;
				else
					cur_x = cur_x - CELL_WIDTH;
				post_result(ACT_ERASE, cur_x, cur_y, '0, 1'b1);
			end
			CHAR_HT: begin
				if (cur_x + TAB_STRIDE >= scr_w)
					line_feed();
				else if (cur_x == 0)
					cur_x = BORDER;
				else
					cur_x = BORDER + ((cur_x - BORDER) / TAB_STRIDE + 1) * TAB_STRIDE;
				post_result(ACT_MOVE, cur_x, cur_y, '0, 1'b1);
			end
			default: begin
				if (cur_x + CELL_WIDTH >= scr_w)
					line_feed();
				if (cur_y + CELL_HEIGHT + BORDER >= scr_h) begin
					cur_x = BORDER;
					cur_y = BORDER;
					post_result(ACT_CLEAR, BORDER, BORDER, '0, 1'b0);
				end
				post_result(ACT_GLYPH, cur_x, cur_y, code, 1'b1);
				cur_x = (cur_x + CELL_WIDTH) & 32'h3FFF;
			end
		endcase
	endfunction

	// scroll mode is almost all line feeds, to run the cursor row well down the screen
	function automatic logic [CODE_W-1:0] pick_char(input bit scroll);
		int unsigned r;
		r = $urandom_range(99);
		if (scroll)
			return (r < 94) ? CHAR_LF : (r < 96) ? CHAR_HT : (r < 98) ? CHAR_CR : CHAR_BS;
		if (r < 12)
			return CHAR_LF;
		if (r < 18)
			return CHAR_CR;
		if (r < 28)
			return CHAR_BS;
		if (r < 38)
			return CHAR_HT;
		return CODE_W'($urandom_range(255));
	endfunction

	task automatic queue_chars(input int n, input bit scroll);
		repeat (n) char_backlog.push_back(pick_char(scroll));
	endtask

	task automatic drain();
		while (char_backlog.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// called at a rising edge with the block idle; valid stays up across the writes
	task automatic set_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input bit spare);
		logic [CFG_INDEX_W-1:0] idx[3];
		logic [DIM_W-1:0] val[3];
		int n;
		idx[0] = REG_WIDTH;
		val[0] = w;
		idx[1] = REG_HEIGHT;
		val[1] = h;
		idx[2] = REG_SPARE;
		val[2] = DIM_W'($urandom_range(16383));
		n = spare ? 3 : 2;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (idx[i] == REG_WIDTH)
				scr_w = val[i];
			else if (idx[i] == REG_HEIGHT)
				scr_h = val[i];
		end
		cfg_valid <= 1'b0;
	endtask

	// driver
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				advance_cursor(char_code);
			if (!in_valid || in_ready) begin
				offer = char_backlog.size() != 0 && !send_hold &&
					$urandom_range(99) >= send_idle_pct;
				if (offer)
					char_code <= char_backlog.pop_front();
				in_valid <= offer;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (!arst_n)
			rx_stall_left <= 0;
		else if (rx_stall_go)
			rx_stall_left <= RX_HOLD_CYCLES;
		else if (rx_stall_left != 0)
			rx_stall_left <= rx_stall_left - 1;
	end

	// monitor
	always @(posedge clk) begin
		cursor_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result item with none expected: action %0d x %0d y %0d",
						action, pos_x, pos_y);
					fail_count++;
				end else begin
					e = due_results.pop_front();
					if (action !== e.act) begin
						$error("action: expected %0d, got %0d", e.act, action);
						fail_count++;
					end
					if (pos_x !== e.x) begin
						$error("pos_x: expected %0d, got %0d", e.x, pos_x);
						fail_count++;
					end
					if (pos_y !== e.y) begin
						$error("pos_y: expected %0d, got %0d", e.y, pos_y);
						fail_count++;
					end
					if (glyph_code !== e.glyph) begin
						$error("glyph_code: expected %0d, got %0d", e.glyph, glyph_code);
						fail_count++;
					end
					if (last !== e.fin) begin
						$error("last: expected %0d, got %0d", e.fin, last);
						fail_count++;
					end
				end
			end
			out_ready <= (rx_stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("text_console_cursor_control: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: glyph extremes, backspace clamp, tab stops up to the edge
		char_backlog = '{8'h41, 8'h00, 8'hFF, CHAR_BS, CHAR_BS, CHAR_BS, CHAR_BS,
			CHAR_HT, CHAR_HT, 8'h7E, CHAR_CR, CHAR_LF, CHAR_HT, CHAR_HT, CHAR_HT,
			CHAR_HT, CHAR_HT, CHAR_HT, CHAR_HT, CHAR_HT, CHAR_HT, CHAR_HT, 8'h20, 8'h80};
		drain();

		set_screen(14'd128, 14'd32, 1'b0);
		queue_chars(100, 1'b0);
		drain();

		// receiver holds off while items keep coming, so the input stalls
		set_screen(14'd8192, 14'd8192, 1'b0);
		queue_chars(300, 1'b0);
		rx_stall_go <= 1'b1;
		@(posedge clk);
		rx_stall_go <= 1'b0;
		drain();

		send_idle_pct <= 49;
		recv_idle_pct <= 27;
		set_screen(14'd16383, 14'd16383, 1'b0);
		queue_chars(600, 1'b1);
		queue_chars(20, 1'b0);
		drain();

		// narrower than one tab stride
		set_screen(14'd40, 14'd200, 1'b0);
		queue_chars(100, 1'b0);
		drain();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		set_screen(14'd0, 14'd0, 1'b1);
		queue_chars(60, 1'b0);
		drain();

		set_screen(14'd1, 14'd16383, 1'b1);
		queue_chars(60, 1'b0);
		drain();

		// sender pauses halfway until every result is back
		set_screen(DIM_W'($urandom_range(8192, 128)), DIM_W'($urandom_range(8192, 32)), 1'b0);
		queue_chars(300, 1'b0);
		while (char_backlog.size() > 150) @(posedge clk);
		send_hold <= 1'b1;
		@(posedge clk);
		while (in_valid || due_results.size() != 0) @(posedge clk);
		send_hold <= 1'b0;
		drain();

		set_screen(WIDTH_RESET, HEIGHT_RESET, 1'b0);
		queue_chars(150, 1'b0);
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("text_console_cursor_control: match");
		else
			$display("text_console_cursor_control: mismatch");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_queue.sv
hw/rtl/tcc_back.sv
hw/rtl/text_console_cursor_control.sv
bench/text_console_cursor_control_test.sv
